// File: sv/fhc_pkg.sv
// ---------------------------------------------------------------------------
// fhc_pkg
// Shared types, register indexes and reset values of the fan controller.
// ---------------------------------------------------------------------------
`default_nettype none

package fhc_pkg;

    localparam int TEMP_W      = 12;
    localparam int TICKS_W     = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int HOLD_COUNT_BITS_DEF = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;

    localparam logic signed [TEMP_W-1:0] FAN_ON_RST   = 12'sd500;
    localparam logic signed [TEMP_W-1:0] FAN_OFF_RST  = 12'sd420;
    localparam logic signed [TEMP_W-1:0] WARN_RST     = 12'sd750;
    localparam logic signed [TEMP_W-1:0] SHUTDOWN_RST = 12'sd850;
    localparam logic [TICKS_W-1:0]       HOLD_RST     = 22'd30000;
    localparam logic signed [TEMP_W-1:0] TEMP_RST     = 12'sd250;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SAMPLE   = 2'd1,
        OP_TX_START = 2'd2,
        OP_TX_END   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [TEMP_W-1:0] sample_temp;
        logic                     sample_valid;
    } item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] fan_on_level;
        logic signed [TEMP_W-1:0] fan_off_level;
        logic signed [TEMP_W-1:0] warn_level;
        logic signed [TEMP_W-1:0] shutdown_level;
        logic [TICKS_W-1:0]       hold_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/fhc_cfg_regs.sv
// ---------------------------------------------------------------------------
// fhc_cfg_regs
// Configuration register file: thresholds and hold length.
// ---------------------------------------------------------------------------
`default_nettype none

module fhc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fhc_pkg::TICKS_W-1:0]      cfg_data,
    output fhc_pkg::cfg_t                         cfg
);

    fhc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fan_on_level   <= fhc_pkg::FAN_ON_RST;
            cfg_reg.fan_off_level  <= fhc_pkg::FAN_OFF_RST;
            cfg_reg.warn_level     <= fhc_pkg::WARN_RST;
            cfg_reg.shutdown_level <= fhc_pkg::SHUTDOWN_RST;
            cfg_reg.hold_ticks     <= fhc_pkg::HOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fhc_pkg::CFG_FAN_ON:   cfg_reg.fan_on_level   <= cfg_data[fhc_pkg::TEMP_W-1:0];
                fhc_pkg::CFG_FAN_OFF:  cfg_reg.fan_off_level  <= cfg_data[fhc_pkg::TEMP_W-1:0];
                fhc_pkg::CFG_WARN:     cfg_reg.warn_level     <= cfg_data[fhc_pkg::TEMP_W-1:0];
                fhc_pkg::CFG_SHUTDOWN: cfg_reg.shutdown_level <= cfg_data[fhc_pkg::TEMP_W-1:0];
                fhc_pkg::CFG_HOLD:     cfg_reg.hold_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/fhc_in_stage.sv
// ---------------------------------------------------------------------------
// fhc_in_stage
// Input register: captures one event beat and holds it for the core.
// ---------------------------------------------------------------------------
`default_nettype none

module fhc_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fhc_pkg::item_t in_item,
    output logic                item_valid,
    input  wire logic           item_ready,
    output fhc_pkg::item_t      item
);

    logic           valid_reg;
    fhc_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/fhc_core.sv
// ---------------------------------------------------------------------------
// fhc_core
// Controller state, per-event update and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fhc_core #(
    parameter int HOLD_COUNT_BITS = fhc_pkg::HOLD_COUNT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire fhc_pkg::cfg_t                cfg,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire fhc_pkg::item_t               item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              fan_drive,
    output logic                              over_temp,
    output logic                              shutdown_request,
    output logic                              hold_active,
    output logic signed [fhc_pkg::TEMP_W-1:0] temperature
);

    localparam int CMP_W = (HOLD_COUNT_BITS > fhc_pkg::TICKS_W) ?
                           HOLD_COUNT_BITS : fhc_pkg::TICKS_W;

    logic signed [fhc_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic                              fan_reg, fan_next;
    logic                              warn_reg, warn_next;
    logic                              hold_reg, hold_next;
    logic [HOLD_COUNT_BITS-1:0]        elapsed_reg, elapsed_next, elapsed_inc;
    logic                              shut;

    logic                              res_valid_reg;
    logic                              res_fan_reg;
    logic                              res_warn_reg;
    logic                              res_shut_reg;
    logic                              res_hold_reg;
    logic signed [fhc_pkg::TEMP_W-1:0] res_temp_reg;

    logic                              advance;

    function automatic logic refresh_fan(
        input logic                              fan,
        input logic                              hold,
        input logic signed [fhc_pkg::TEMP_W-1:0] t,
        input fhc_pkg::cfg_t                     c
    );
        logic r;
        if (!fan)
        begin
            r = hold || (t >= c.fan_on_level);
        end
        else
        begin
            r = !(!hold && (t < c.fan_off_level));
        end
        return r;
    endfunction

    assign advance    = !res_valid_reg || out_ready;
    assign item_ready = advance;

    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        temp_next    = temp_reg;
        fan_next     = fan_reg;
        warn_next    = warn_reg;
        hold_next    = hold_reg;
        elapsed_next = elapsed_reg;
        shut         = 1'b0;
        case (item.op)
            fhc_pkg::OP_TICK:
            begin
                if (hold_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (CMP_W'(elapsed_inc) >= CMP_W'(cfg.hold_ticks))
                    begin
                        hold_next = 1'b0;
                        fan_next  = refresh_fan(fan_reg, 1'b0, temp_reg, cfg);
                    end
                end
            end
            fhc_pkg::OP_SAMPLE:
            begin
                if (item.sample_valid)
                begin
                    temp_next = item.sample_temp;
                end
                warn_next = (temp_next >= cfg.warn_level);
                if (temp_next >= cfg.shutdown_level)
                begin
                    shut = 1'b1;
                end
                else
                begin
                    fan_next = refresh_fan(fan_reg, hold_reg, temp_next, cfg);
                end
            end
            fhc_pkg::OP_TX_START:
            begin
                fan_next = 1'b1;
            end
            fhc_pkg::OP_TX_END:
            begin
                elapsed_next = '0;
                hold_next    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg      <= fhc_pkg::TEMP_RST;
            fan_reg       <= 1'b0;
            warn_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            elapsed_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid;
            if (item_valid)
            begin
                temp_reg    <= temp_next;
                fan_reg     <= fan_next;
                warn_reg    <= warn_next;
                hold_reg    <= hold_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            res_fan_reg  <= fan_next;
            res_warn_reg <= warn_next;
            res_shut_reg <= shut;
            res_hold_reg <= hold_next;
            res_temp_reg <= temp_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign fan_drive        = res_fan_reg;
    assign over_temp        = res_warn_reg;
    assign shutdown_request = res_shut_reg;
    assign hold_active      = res_hold_reg;
    assign temperature      = res_temp_reg;

endmodule

`default_nettype wire

// File: sv/fan_hysteresis_cooldown_ctrl_top.sv
// ---------------------------------------------------------------------------
// fan_hysteresis_cooldown_ctrl_top
// Event-driven fan controller with hysteresis and post-transmit cooldown hold.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    op, sample_temp, sample_valid
//  out      out_valid / out_ready  fan_drive, over_temp, shutdown_request,
//                                  hold_active, temperature
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One event beat per cycle while the result is not stalled; an accepted beat
//  passes the input register, then the state update into the result register.
//  rst_n clears state to 25.0 degrees, fan off, no hold, default levels.
//  cfg_ready is always high. A stalled result holds in the result register;
//  the input register still takes one more beat behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module fan_hysteresis_cooldown_ctrl_top #(
    parameter int HOLD_COUNT_BITS = fhc_pkg::HOLD_COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       op,
    input  wire logic signed [fhc_pkg::TEMP_W-1:0] sample_temp,
    input  wire logic                             sample_valid,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  fan_drive,
    output logic                                  over_temp,
    output logic                                  shutdown_request,
    output logic                                  hold_active,
    output logic signed [fhc_pkg::TEMP_W-1:0]     temperature,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fhc_pkg::TICKS_W-1:0]      cfg_data
);

    fhc_pkg::cfg_t  cfg;
    fhc_pkg::item_t in_item;
    fhc_pkg::item_t item;
    logic           item_valid;
    logic           item_ready;

    assign in_item.op           = fhc_pkg::op_t'(op);
    assign in_item.sample_temp  = sample_temp;
    assign in_item.sample_valid = sample_valid;

    fhc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fhc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    fhc_core #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .fan_drive        (fan_drive),
        .over_temp        (over_temp),
        .shutdown_request (shutdown_request),
        .hold_active      (hold_active),
        .temperature      (temperature)
    );

endmodule

`default_nettype wire

// File: sv/fhc_checker.sv
// ---------------------------------------------------------------------------
// fhc_checker
// Port-level checks of the fan controller, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fhc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    // stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // input backpressure only from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // a fresh result follows an accepted input beat through the input and result registers
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without matching input beat");

endmodule

bind fan_hysteresis_cooldown_ctrl_top fhc_checker u_fhc_checker (.*);

`default_nettype wire
